>>> sv/cbbz_pkg.sv
// Shared types, constants and elaboration-time helpers for the cubic B-spline
// to Bezier converter. Depends on nothing; front, back, top and testbench import it.
package cbbz_pkg;

  // Default coordinate width (signed Q16.16 at 32 bits).
  localparam int COORD_WIDTH_DEF = 32;

  // Default depth of the job queue between the front and back ends.
  localparam int JOB_FIFO_DEPTH = 2;

  // Describes which Bezier points one centre job produces.
  typedef struct packed {
    logic with_prev;
    logic with_next;
    logic last;
  } job_flags_t;

  // Returns floor(2^k / 3) + 1, the reciprocal used for division by three.
  // Evaluated at elaboration only.
  function automatic logic [127:0] recip3(input int k);
    logic [127:0] quo;
    logic [2:0]   rem;
    quo = '0;
    rem = 3'd1;
    for (int i = k - 1; i >= 0; i--) begin
      rem = {rem[1:0], 1'b0};
      if (rem >= 3'd3) begin
        quo[i] = 1'b1;
        rem    = rem - 3'd3;
      end
    end
    return quo + 128'd1;
  endfunction

endpackage

>>> sv/cbbz_fifo.sv
// Small flop-based FIFO that carries jobs from the front end to the back end.
// Generic in width and depth; uses no package items.
module cbbz_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  always_comb begin
    push_ready_o = (cnt_q != CNT_W'(DEPTH));
    pop_valid_o  = (cnt_q != '0);
    pop_data_o   = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_valid_o && pop_ready_i;

    wr_ptr_d = wr_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    rd_ptr_d = rd_ptr_q;
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/cbbz_front.sv
// Front end: accepts de Boor points, keeps the three-point window and the
// position count, and turns each point into zero, one or two centre jobs.
// Depends on cbbz_pkg.
module cbbz_front #(
  parameter int W = cbbz_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [W-1:0]         in_x_i,
  input  logic [W-1:0]         in_y_i,
  input  logic [W-1:0]         in_z_i,
  input  logic                 curve_end_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output logic [9*W-1:0]       job_pts_o,
  output cbbz_pkg::job_flags_t job_flags_o
);

  import cbbz_pkg::*;

  localparam logic [2:0] PosFirstInterior = 3'd3;
  localparam logic [2:0] PosFull          = 3'd4;

  logic [3*W-1:0] w0_q, w1_q, w2_q, w0_d, w1_d, w2_d;
  logic [2:0]     pos_q, pos_d;
  logic           a_v_q, a_v_d, b_v_q, b_v_d;
  logic [9*W-1:0] a_pts_q, b_pts_q;
  job_flags_t     a_flags_q, b_flags_q, a_flags_d, b_flags_d;
  logic [3*W-1:0] pt;
  logic           push, a_keep, b_keep, accept, has_job;

  always_comb begin
    job_valid_o = a_v_q || b_v_q;
    job_pts_o   = a_v_q ? a_pts_q : b_pts_q;
    job_flags_o = a_v_q ? a_flags_q : b_flags_q;
    push        = job_valid_o && job_ready_i;
    a_keep      = a_v_q && !push;
    b_keep      = b_v_q && !(push && !a_v_q);
    in_stall_o  = a_keep || b_keep;
    accept      = in_valid_i && !in_stall_o;
    pt          = {in_x_i, in_y_i, in_z_i};
    has_job     = (pos_q >= PosFirstInterior);

    a_flags_d.with_prev = (pos_q >= PosFull);
    a_flags_d.with_next = 1'b1;
    a_flags_d.last      = !curve_end_i;
    b_flags_d.with_prev = 1'b1;
    b_flags_d.with_next = 1'b0;
    b_flags_d.last      = 1'b1;

    a_v_d = a_keep;
    b_v_d = b_keep;
    w0_d  = w0_q;
    w1_d  = w1_q;
    w2_d  = w2_q;
    pos_d = pos_q;
    if (accept) begin
      a_v_d = has_job;
      b_v_d = has_job && curve_end_i;
      if (curve_end_i) begin
        w0_d  = '0;
        w1_d  = '0;
        w2_d  = '0;
        pos_d = '0;
      end else begin
        w0_d  = w1_q;
        w1_d  = w2_q;
        w2_d  = pt;
        pos_d = (pos_q == PosFull) ? pos_q : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      w0_q  <= '0;
      w1_q  <= '0;
      w2_q  <= '0;
      pos_q <= '0;
    end else begin
      a_v_q <= a_v_d;
      b_v_q <= b_v_d;
      w0_q  <= w0_d;
      w1_q  <= w1_d;
      w2_q  <= w2_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pts_q   <= {w0_q, w1_q, w2_q};
      b_pts_q   <= {w1_q, w2_q, pt};
      a_flags_q <= a_flags_d;
      b_flags_q <= b_flags_d;
    end
  end

endmodule

>>> sv/cbbz_back.sv
// Back end: a five-stage arithmetic pipeline that forms prev, centre and next
// of one centre job, followed by a serializer and the output register.
// Depends on cbbz_pkg.
module cbbz_back #(
  parameter int W = cbbz_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  logic [9*W-1:0]       job_pts_i,
  input  cbbz_pkg::job_flags_t job_flags_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3*W-1:0]       out_pt_o,
  output logic                 run_last_o
);

  import cbbz_pkg::*;

  localparam int DW = W + 1;            // difference width
  localparam int H  = (DW + 1) / 2;     // partial product split
  localparam int K  = DW + 1;           // reciprocal shift
  localparam int PW = 4 * H + 2;        // product sum width
  localparam logic [127:0] RecipFull = recip3(K);
  localparam logic [DW-1:0] Recip    = RecipFull[DW-1:0];
  localparam logic [H-1:0]  RecipLo  = Recip[H-1:0];
  localparam logic [H-1:0]  RecipHi  = H'(Recip >> H);

  localparam int MaskPrev   = 2;
  localparam int MaskCentre = 1;
  localparam int MaskNext   = 0;

  // Stage valids and load enables.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  // Stage 1: magnitudes and signs of the six differences.
  logic [DW-1:0]  mag1_d [6];
  logic [DW-1:0]  mag1_q [6];
  logic [5:0]     sgn1_d, sgn1_q;
  logic [3*W-1:0] c1_q;
  job_flags_t     fl1_q;

  // Stage 2: partial products.
  logic [2*H-1:0] ll2_d [6];
  logic [2*H-1:0] lh2_d [6];
  logic [2*H-1:0] hl2_d [6];
  logic [2*H-1:0] hh2_d [6];
  logic [2*H-1:0] ll2_q [6];
  logic [2*H-1:0] lh2_q [6];
  logic [2*H-1:0] hl2_q [6];
  logic [2*H-1:0] hh2_q [6];
  logic [5:0]     sgn2_q;
  logic [3*W-1:0] c2_q;
  job_flags_t     fl2_q;

  // Stage 3: truncated quotients by three.
  logic [PW-1:0]  psum [6];
  logic [DW-1:0]  q3_d [6];
  logic [DW-1:0]  q3_q [6];
  logic [5:0]     sgn3_q;
  logic [3*W-1:0] c3_q;
  job_flags_t     fl3_q;

  // Stage 4: prev and next points.
  logic [DW:0]    pv_sum [3];
  logic [DW:0]    nx_sum [3];
  logic [3*W-1:0] pv4_d, nx4_d, pv4_q, nx4_q;
  job_flags_t     fl4_q;

  // Stage 5: centre point.
  logic [DW-1:0]  ce_sum [3];
  logic [DW-1:0]  ce_rnd [3];
  logic [3*W-1:0] ce5_d, pv5_q, ce5_q, nx5_q;
  job_flags_t     fl5_q;

  // Serializer and output register.
  logic           jv_q, jv_d;
  logic [2:0]     jmask_q, jmask_d, mask_after;
  logic           jlast_q;
  logic [3*W-1:0] jpv_q, jce_q, jnx_q, sel_pt;
  logic           out_v_q, out_v_d, out_last_q, out_free, emit, fin;
  logic [3*W-1:0] out_pt_q;

  logic [DW-1:0]  d_a, d_b;
  logic [W-1:0]   pc, cc, nc;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pc = job_pts_i[6*W + j*W +: W];
      cc = job_pts_i[3*W + j*W +: W];
      nc = job_pts_i[j*W +: W];
      d_a = {pc[W-1], pc} - {cc[W-1], cc};
      d_b = {cc[W-1], cc} - {pc[W-1], pc};
      sgn1_d[2*j] = d_a[DW-1];
      mag1_d[2*j] = d_a[DW-1] ? d_b : d_a;
      d_a = {nc[W-1], nc} - {cc[W-1], cc};
      d_b = {cc[W-1], cc} - {nc[W-1], nc};
      sgn1_d[2*j+1] = d_a[DW-1];
      mag1_d[2*j+1] = d_a[DW-1] ? d_b : d_a;
    end

    for (int k = 0; k < 6; k++) begin
      ll2_d[k] = (2*H)'(mag1_q[k][H-1:0]) * (2*H)'(RecipLo);
      lh2_d[k] = (2*H)'(mag1_q[k][H-1:0]) * (2*H)'(RecipHi);
      hl2_d[k] = (2*H)'(H'(mag1_q[k] >> H)) * (2*H)'(RecipLo);
      hh2_d[k] = (2*H)'(H'(mag1_q[k] >> H)) * (2*H)'(RecipHi);
    end

    for (int k = 0; k < 6; k++) begin
      psum[k] = PW'({hh2_q[k], ll2_q[k]}) + (PW'(lh2_q[k]) << H)
              + (PW'(hl2_q[k]) << H);
      q3_d[k] = psum[k][K +: DW];
    end

    for (int j = 0; j < 3; j++) begin
      pv_sum[j] = {{2{c3_q[j*W + W - 1]}}, c3_q[j*W +: W]}
                + ({1'b0, q3_q[2*j]} ^ {(DW+1){sgn3_q[2*j]}})
                + (DW+1)'(sgn3_q[2*j]);
      nx_sum[j] = {{2{c3_q[j*W + W - 1]}}, c3_q[j*W +: W]}
                + ({1'b0, q3_q[2*j+1]} ^ {(DW+1){sgn3_q[2*j+1]}})
                + (DW+1)'(sgn3_q[2*j+1]);
      pv4_d[j*W +: W] = pv_sum[j][W-1:0];
      nx4_d[j*W +: W] = nx_sum[j][W-1:0];
    end

    // Halve the sum, truncating toward zero.
    for (int j = 0; j < 3; j++) begin
      ce_sum[j] = {pv4_q[j*W + W - 1], pv4_q[j*W +: W]}
                + {nx4_q[j*W + W - 1], nx4_q[j*W +: W]};
      ce_rnd[j] = ce_sum[j] + DW'(ce_sum[j][DW-1]);
      ce5_d[j*W +: W] = ce_rnd[j][DW-1:1];
    end
  end

  // Serializer: prev, then centre, then next, each only if present.
  always_comb begin
    out_free   = !out_v_q || !out_stall_i;
    emit       = jv_q && out_free;
    mask_after = jmask_q;
    sel_pt     = jnx_q;
    if (jmask_q[MaskPrev]) begin
      sel_pt               = jpv_q;
      mask_after[MaskPrev] = 1'b0;
    end else if (jmask_q[MaskCentre]) begin
      sel_pt                 = jce_q;
      mask_after[MaskCentre] = 1'b0;
    end else begin
      mask_after[MaskNext] = 1'b0;
    end
    fin = (mask_after == '0);

    ld6 = !jv_q || (emit && fin);
    ld5 = !v5_q || ld6;
    ld4 = !v4_q || ld5;
    ld3 = !v3_q || ld4;
    ld2 = !v2_q || ld3;
    ld1 = !v1_q || ld2;
    job_ready_o = ld1;

    jv_d    = jv_q;
    jmask_d = jmask_q;
    if (ld6) begin
      jv_d    = v5_q;
      jmask_d = {fl5_q.with_prev, 1'b1, fl5_q.with_next};
    end else if (emit) begin
      jmask_d = mask_after;
    end

    out_v_d = emit ? 1'b1 : (out_free ? 1'b0 : out_v_q);

    out_valid_o = out_v_q;
    out_pt_o    = out_pt_q;
    run_last_o  = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      jv_q    <= 1'b0;
      jmask_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= job_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
      jv_q    <= jv_d;
      jmask_q <= jmask_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      mag1_q <= mag1_d;
      sgn1_q <= sgn1_d;
      c1_q   <= job_pts_i[3*W +: 3*W];
      fl1_q  <= job_flags_i;
    end
    if (ld2) begin
      ll2_q  <= ll2_d;
      lh2_q  <= lh2_d;
      hl2_q  <= hl2_d;
      hh2_q  <= hh2_d;
      sgn2_q <= sgn1_q;
      c2_q   <= c1_q;
      fl2_q  <= fl1_q;
    end
    if (ld3) begin
      q3_q   <= q3_d;
      sgn3_q <= sgn2_q;
      c3_q   <= c2_q;
      fl3_q  <= fl2_q;
    end
    if (ld4) begin
      pv4_q <= pv4_d;
      nx4_q <= nx4_d;
      fl4_q <= fl3_q;
    end
    if (ld5) begin
      pv5_q <= pv4_q;
      ce5_q <= ce5_d;
      nx5_q <= nx4_q;
      fl5_q <= fl4_q;
    end
    if (ld6) begin
      jpv_q   <= pv5_q;
      jce_q   <= ce5_q;
      jnx_q   <= nx5_q;
      jlast_q <= fl5_q.last;
    end
    if (emit) begin
      out_pt_q   <= sel_pt;
      out_last_q <= jlast_q && fin;
    end
  end

endmodule

>>> sv/cubic_bspline_to_bezier_points.sv
// Top level of the uniform cubic B-spline to Bezier converter.
// Instantiates cbbz_front, cbbz_fifo and cbbz_back; depends on cbbz_pkg.
//
// This block turns a stream of 3D de Boor points (signed Q16.16 by default,
// one point per transaction, curve_end_i on the last point of a curve) into
// the Bezier control points of the equivalent piecewise cubic curve. For
// every interior point C with neighbours P and N it forms prev = C + (P-C)/3,
// next = C + (N-C)/3 and centre = (prev+next)/2, each division truncating
// toward zero. Output lags input by two points: the fourth point of a curve
// yields centre and next of the first interior point, each further point
// yields prev, centre and next of the point two back, and the closing point
// adds prev and centre of the last interior point, so a curve of n >= 4
// points gives 3n-8 results and shorter curves give none. run_last_o marks
// the final result of each input transaction. The front end accepts a point
// per cycle while its job registers are free, and stalls on a closing point
// that produces two jobs until the second one is queued; the back end
// delivers one result per cycle through its output register while the
// output is not stalled. An input point causes up to five results, and
// about three on long curves. The first result of a point passes the job
// register (loaded by the accepting edge), the queue, the five arithmetic
// stages, the serializer and the output register in that order. Both
// channels use valid/stall; a result waiting under stall does not block new
// input until the job queue and pipeline fill.
module cubic_bspline_to_bezier_points #(
  parameter int COORD_WIDTH = cbbz_pkg::COORD_WIDTH_DEF,
  parameter int JOB_DEPTH   = cbbz_pkg::JOB_FIFO_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_WIDTH-1:0] in_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_y_i,
  input  logic signed [COORD_WIDTH-1:0] in_z_i,
  input  logic                          curve_end_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          run_last_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);

  import cbbz_pkg::*;

  localparam int JobW = 9 * COORD_WIDTH + $bits(job_flags_t);

  // Jobs leaving the front end.
  logic                     fj_valid, fj_ready;
  logic [9*COORD_WIDTH-1:0] fj_pts;
  job_flags_t               fj_flags;

  // Jobs entering the back end.
  logic                     bj_valid, bj_ready;
  logic [9*COORD_WIDTH-1:0] bj_pts;
  job_flags_t               bj_flags;

  logic [3*COORD_WIDTH-1:0] out_pt;

  cbbz_front #(
    .W (COORD_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .curve_end_i (curve_end_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_pts_o   (fj_pts),
    .job_flags_o (fj_flags)
  );

  // The job queue lets the front end keep accepting points while the back
  // end works through, or is stalled on, earlier jobs.
  cbbz_fifo #(
    .DATA_W (JobW),
    .DEPTH  (JOB_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  ({fj_flags, fj_pts}),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   ({bj_flags, bj_pts})
  );

  cbbz_back #(
    .W (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_pts_i   (bj_pts),
    .job_flags_i (bj_flags),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pt_o    (out_pt),
    .run_last_o  (run_last_o)
  );

  // Points travel packed as {x, y, z}.
  assign out_x_o = out_pt[2*COORD_WIDTH +: COORD_WIDTH];
  assign out_y_o = out_pt[COORD_WIDTH +: COORD_WIDTH];
  assign out_z_o = out_pt[0 +: COORD_WIDTH];

endmodule

>>> sv/cbbz_checker.sv
// Port-level checker for the B-spline to Bezier converter, bound to the top
// level below. Uses only the top-level ports; no package items.
module cbbz_checker #(
  parameter int W = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input logic [W-1:0] out_x_o,
  input logic [W-1:0] out_y_o,
  input logic [W-1:0] out_z_o,
  input logic         run_last_o,
  input logic         out_valid_o,
  input logic         out_stall_i
);

  logic [2:0] in_cnt_q;   // input transactions since reset, saturating at 4
  logic [2:0] nl_cnt_q;   // results since the last run_last

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q <= '0;
      nl_cnt_q <= '0;
    end else begin
      if (in_valid_i && !in_stall_o && in_cnt_q != 3'd4) begin
        in_cnt_q <= in_cnt_q + 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        nl_cnt_q <= run_last_o ? 3'd0 : nl_cnt_q + 1'b1;
      end
    end
  end

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_x_o) && $stable(out_y_o)
      && $stable(out_z_o) && $stable(run_last_o))
    else $error("result payload changed while stalled");

  // A single point causes at most five results, so at most four in a row
  // can go without run_last.
  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |-> nl_cnt_q < 3'd4)
    else $error("too many results without run_last");

  // No result can exist before four points have been taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_cnt_q == 3'd4)
    else $error("result before the fourth point");

endmodule

bind cubic_bspline_to_bezier_points cbbz_checker #(
  .W (COORD_WIDTH)
) u_cbbz_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .run_last_o  (run_last_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

>>> dv/testbench.sv
// Self-checking testbench for cubic_bspline_to_bezier_points (B-spline to Bezier converter).
// Depends on cbbz_pkg and the converter RTL only; no files, plusargs or external models.
`timescale 1ns / 100ps

module testbench;

  import cbbz_pkg::COORD_WIDTH_DEF;

  localparam int CW        = COORD_WIDTH_DEF;
  // Cycle budget for the whole run. A long curve costs about three results per
  // point, and the heaviest stall mix holds each result back further, so
  // this is several times the slowest correct run.
  localparam int MAX_CYCLES = 400000;
  // After the last expected result we linger well beyond the path from the
  // accepting edge to the first result.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_POINTS = 105;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t trip_t [3];

  // One de Boor point as it crosses the input channel.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   fin;
  } boor_t;

  // One Bezier control point as it leaves on the output channel.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } bez_t;

  localparam coord_t CRD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CRD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Clock, reset and the signals wired to the converter. Every input of the
  // block starts at a known value.
  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  coord_t in_x      = '0;
  coord_t in_y      = '0;
  coord_t in_z      = '0;
  logic   curve_end = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_stall;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   run_last;
  logic   out_valid;
  logic   out_stall = 1'b0;

  cubic_bspline_to_bezier_points i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_x_i      (in_x),
    .in_y_i      (in_y),
    .in_z_i      (in_z),
    .curve_end_i (curve_end),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .run_last_o  (run_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus waiting to be sent, and the Bezier points still owed by the block.
  boor_t pending_pts [$];
  bez_t  bezier_q [$];

  // Mirror of the converter's state: the three most recent de Boor points of
  // the open curve (oldest first) and how many points of it have arrived,
  // saturating at four.
  trip_t       win_pts [3];
  int unsigned pos_cnt;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned pts_queued  = 0;
  int unsigned pts_taken   = 0;
  int unsigned curves      = 0;
  int unsigned bez_checked = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;
  logic        in_taken    = 1'b0;

  // C + (D - C) / 3, with the division truncating toward zero. The difference
  // needs one bit more than a coordinate, so the arithmetic runs in 64 bits.
  function automatic coord_t third_toward(coord_t c, coord_t d);
    longint q;
    q = (longint'(d) - longint'(c)) / 3;
    return coord_t'(longint'(c) + q);
  endfunction

  // (A + B) / 2, truncating toward zero.
  function automatic coord_t half_sum(coord_t a, coord_t b);
    return coord_t'((longint'(a) + longint'(b)) / 2);
  endfunction

  function automatic bez_t as_bez(trip_t t, logic last);
    bez_t b;
    b.x    = t[0];
    b.y    = t[1];
    b.z    = t[2];
    b.last = last;
    return b;
  endfunction

  // Queues the Bezier points around centre cc with neighbours pp and nn, in the
  // order prev, centre, next. When closes is set, the final point of the group
  // is also the final result of the input transaction and carries run_last.
  function automatic void queue_centre_group(trip_t pp, trip_t cc, trip_t nn,
                                             logic with_prev, logic with_next,
                                             logic closes);
    trip_t pv;
    trip_t nx;
    trip_t ce;
    for (int j = 0; j < 3; j++) begin
      pv[j] = third_toward(cc[j], pp[j]);
      nx[j] = third_toward(cc[j], nn[j]);
      ce[j] = half_sum(pv[j], nx[j]);
    end
    if (with_prev) bezier_q.insert(bezier_q.size(), as_bez(pv, 1'b0));
    bezier_q.insert(bezier_q.size(), as_bez(ce, closes && !with_next));
    if (with_next) bezier_q.insert(bezier_q.size(), as_bez(nx, closes));
  endfunction

  // Works out every Bezier point one accepted de Boor point causes. Output lags
  // by two points: once three points of a curve are held, each new point
  // releases the point two back (without its prev half while it is still the
  // first interior point). A closing point also releases prev and centre of
  // the point one back, then the curve state clears. Curves shorter than four
  // points never reach the emitting count and give nothing.
  function automatic void predict_bezier(boor_t p);
    trip_t np;
    np = '{p.x, p.y, p.z};
    if (pos_cnt >= 3)
      queue_centre_group(win_pts[0], win_pts[1], win_pts[2], pos_cnt >= 4, 1'b1, !p.fin);
    if (p.fin) begin
      if (pos_cnt >= 3)
        queue_centre_group(win_pts[1], win_pts[2], np, 1'b1, 1'b0, 1'b1);
      for (int k = 0; k < 3; k++) win_pts[k] = '{default: '0};
      pos_cnt = 0;
    end else begin
      win_pts[0] = win_pts[1];
      win_pts[1] = win_pts[2];
      win_pts[2] = np;
      if (pos_cnt < 4) pos_cnt++;
    end
  endfunction

  // Extreme coordinate values, cycled by index.
  function automatic coord_t corner_val(int k);
    case (k % 5)
      0: return CRD_MAX;
      1: return CRD_MIN;
      2: return '0;
      3: return '1;
      default: return coord_t'(1);
    endcase
  endfunction

  // Half of all picks are full-range words, so every bit of every coordinate toggles; some
  // points near the origin (within +/-8.0 in Q16.16), some at the extremes.
  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return coord_t'($urandom);
    if (sel < 8) return coord_t'(int'($urandom_range(0, 2 * 8 * 65536)) - 8 * 65536);
    return corner_val($urandom_range(4));
  endfunction

  task automatic add_pt(coord_t x, coord_t y, coord_t z, logic fin);
    boor_t p;
    p.x   = x;
    p.y   = y;
    p.z   = z;
    p.fin = fin;
    pending_pts.insert(pending_pts.size(), p);
    pts_queued++;
    if (fin) curves++;
  endtask

  task automatic queue_curve(int len);
    for (int i = 0; i < len; i++)
      add_pt(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
  endtask

  // Holds until every queued point has been taken and every Bezier point it
  // owes has come out. No new points are queued during the wait.
  task automatic wait_drained();
    while (pts_taken != pts_queued || bezier_q.size() != 0) @(posedge clk);
  endtask

  // Input driver. Inputs move on the falling edge. A new point is offered only
  // once the previous one went through (or nothing was offered), and the idle
  // decision is a coin toss that never looks at in_stall, so a stalled payload
  // stays put and valid stays high until the transaction completes.
  always @(negedge clk) begin : drive_pts
    boor_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_pts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_pts.pop_front();
        in_x      <= nxt.x;
        in_y      <= nxt.y;
        in_z      <= nxt.z;
        curve_end <= nxt.fin;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure, independent of out_valid.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor on the rising edge: records accepted input transactions into the
  // predictor, then checks each accepted output transaction against the oldest
  // expected Bezier point, field by field.
  always @(posedge clk) begin : watch_ports
    bez_t want;
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles: %0d of %0d points taken, %0d results owed",
               cycle_cnt, pts_taken, pts_queued, bezier_q.size());
      $display("testbench: errors");
      $finish;
    end
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_bezier('{in_x, in_y, in_z, curve_end});
        pts_taken++;
      end
      if (out_valid && !out_stall) begin
        if (bezier_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result at cycle %0d: x=%0d y=%0d z=%0d last=%b",
                     cycle_cnt, out_x, out_y, out_z, run_last);
        end else begin
          want = bezier_q.pop_front();
          bez_checked++;
          if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
              run_last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch at cycle %0d: expected x=%0d y=%0d z=%0d last=%b,",
                       cycle_cnt, want.x, want.y, want.z, want.last,
                       " got x=%0d y=%0d z=%0d last=%b",
                       out_x, out_y, out_z, run_last);
          end
        end
      end
    end
  end

  // Stimulus sequence. Four idling phases: none, sender idle, receiver
  // stalling, both. Between phases the sender waits for every owed result, so
  // the block drains completely at least once mid-run.
  initial begin : run_phases
    int unsigned idle_tbl [4];
    int unsigned stall_tbl [4];
    int          n_pts;
    int          len;
    int unsigned sel;
    idle_tbl  = '{0, 56, 0, 20};
    stall_tbl = '{0, 0, 56, 20};
    for (int k = 0; k < 3; k++) win_pts[k] = '{default: '0};
    pos_cnt = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tbl[ph];
      recv_stall_pct = stall_tbl[ph];
      if (ph == 0) begin
        // Curves of one to six points made only of extreme values: the short
        // ones that close before anything is emitted, the four-point curve
        // that gives only its opening and closing groups, and longer ones where
        // the count saturates. Some neighbouring points swing between the most
        // negative and most positive coordinates.
        for (int n = 1; n <= 6; n++)
          for (int i = 0; i < n; i++)
            add_pt(corner_val(i + n), corner_val(i + n + 1), corner_val(i + 2 * n + 2),
                   i == n - 1);
      end
      // Mostly well-formed curves of four or more points; some one to three
      // points long, which close without producing anything.
      n_pts = 0;
      while (n_pts < PHASE_POINTS) begin
        sel = $urandom_range(99);
        if (sel < 12)      len = $urandom_range(1, 3);
        else if (sel < 88) len = $urandom_range(4, 9);
        else               len = $urandom_range(10, 30);
        queue_curve(len);
        n_pts += len;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d de Boor points in %0d curves sent over four idling phases",
             pts_taken, curves);
    $display("summary: %0d Bezier points checked, %0d mismatches", bez_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
